[hdl/bgc_pkg.sv]
// shared constants and types of the button gesture classifier
`default_nettype none

package bgc_pkg;

    localparam int USER_BUTTONS = 4;
    localparam int NUM_SLOTS    = USER_BUTTONS + 1;
    localparam int BOOT_SLOT    = USER_BUTTONS;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    // factory or pin event, boot pairing, one per user button
    localparam int NUM_EVT      = USER_BUTTONS + 2;

    localparam int BTN_W        = 3;
    localparam int TIME_W       = 32;
    localparam int CLICK_W      = 2;
    localparam int SHORT_CFG_W  = 16;
    localparam int LONG_CFG_W   = 18;

    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 18;

    localparam int IN_DATA_W    = 40;
    localparam int OUT_DATA_W   = 40;

    localparam logic [BTN_W-1:0] BOOT_ID    = BTN_W'(USER_BUTTONS + 1);
    localparam logic [BTN_W-1:0] FACTORY_ID = '0;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FACTORY   = 3'd4;

    localparam logic [SHORT_CFG_W-1:0] DEBOUNCE_RST  = 16'd50;
    localparam logic [SHORT_CFG_W-1:0] DOUBLE_RST    = 16'd300;
    localparam logic [SHORT_CFG_W-1:0] LONG_RST      = 16'd1000;
    localparam logic [LONG_CFG_W-1:0]  VERY_LONG_RST = 18'd10000;
    localparam logic [LONG_CFG_W-1:0]  FACTORY_RST   = 18'd10000;

    typedef enum logic [2:0] {
        KIND_SHORT   = 3'd0,
        KIND_DOUBLE  = 3'd1,
        KIND_LONG    = 3'd2,
        KIND_PAIRING = 3'd3,
        KIND_FACTORY = 3'd4
    } t_kind;

endpackage

`default_nettype wire

[hdl/button_gesture_classifier.sv]
// button gesture classifier: press tracking, gesture events and result drain
// path: input register, then pending results, then output register to m_axis
// throughput: one item per cycle while items give at most one result each and m_axis
//   is ready; an item with more results holds the next until its last result loads
// the single output register sets the rate: one result per cycle while m_axis is ready
// reset: synchronous active low; clears button state, pending results and restores
//   the register defaults
`default_nettype none

module button_gesture_classifier (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // slave side
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] button_id, [3] pin_level, [35:4] time_ms, [39:36] zero
    input  wire logic [bgc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [0] cmd
    input  wire logic                          s_axis_tuser,
    // master side
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [2:0] event_button, [34:3] event_time, [39:35] zero
    output logic [bgc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [2:0] event_kind
    output logic [2:0]                         m_axis_tuser,
    output logic                               m_axis_tlast,
    // configuration writes
    input  wire logic                          i_cfg_we,
    input  wire logic [bgc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bgc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import bgc_pkg::*;

    // configuration
    logic [SHORT_CFG_W-1:0] r_debounce;
    logic [SHORT_CFG_W-1:0] r_double;
    logic [SHORT_CFG_W-1:0] r_long;
    logic [LONG_CFG_W-1:0]  r_very_long;
    logic [LONG_CFG_W-1:0]  r_factory;

    // input register
    logic              r_in_valid;
    logic              r_in_cmd;
    logic [BTN_W-1:0]  r_in_btn;
    logic              r_in_level;
    logic [TIME_W-1:0] r_in_time;

    // button state
    logic               r_is_down     [NUM_SLOTS];
    logic [TIME_W-1:0]  r_press_start [NUM_SLOTS];
    logic [TIME_W-1:0]  r_last_press  [NUM_SLOTS];
    logic               r_hold_rep    [NUM_SLOTS];
    logic [CLICK_W-1:0] r_click       [NUM_SLOTS];
    logic               r_all_latch;
    logic [TIME_W-1:0]  r_all_start;

    logic               n_is_down     [NUM_SLOTS];
    logic [TIME_W-1:0]  n_press_start [NUM_SLOTS];
    logic [TIME_W-1:0]  n_last_press  [NUM_SLOTS];
    logic               n_hold_rep    [NUM_SLOTS];
    logic [CLICK_W-1:0] n_click       [NUM_SLOTS];
    logic               n_all_latch;
    logic [TIME_W-1:0]  n_all_start;

    // pending results of the item last processed
    logic [NUM_EVT-1:0] r_pend_mask;
    logic [BTN_W-1:0]   r_pend_btn  [NUM_EVT];
    t_kind              r_pend_kind [NUM_EVT];
    logic [TIME_W-1:0]  r_pend_time;

    // output register
    logic              r_out_valid;
    logic [BTN_W-1:0]  r_out_btn;
    t_kind             r_out_kind;
    logic [TIME_W-1:0] r_out_time;
    logic              r_out_last;

    // event logic
    logic [TIME_W-1:0]  held_d  [NUM_SLOTS];
    logic [TIME_W-1:0]  since_d [NUM_SLOTS];
    logic [NUM_EVT-1:0] ev_mask;
    logic [BTN_W-1:0]   ev_btn  [NUM_EVT];
    t_kind              ev_kind [NUM_EVT];
    logic               pin_ok;
    logic               pin_pressed;
    logic [SLOT_W-1:0]  pin_slot;
    logic               all_down;

    // drain control
    logic               out_free;
    logic               load_out;
    logic [NUM_EVT-1:0] pend_low;
    logic [NUM_EVT-1:0] pend_rest;
    logic [NUM_EVT-1:0] pend_after;
    logic               proc_fire;
    logic               in_fire;
    logic [BTN_W-1:0]   sel_btn;
    t_kind              sel_kind;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign load_out      = out_free && (r_pend_mask != '0);
    assign pend_low      = r_pend_mask & (~r_pend_mask + NUM_EVT'(1));
    assign pend_rest     = r_pend_mask & ~pend_low;
    assign pend_after    = load_out ? pend_rest : r_pend_mask;
    assign proc_fire     = r_in_valid && (pend_after == '0);
    assign s_axis_tready = !r_in_valid || proc_fire;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - TIME_W - BTN_W)'(0), r_out_time, r_out_btn};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // lowest pending position goes out first
    always_comb begin
        sel_btn  = '0;
        sel_kind = KIND_SHORT;
        for (int i = 0; i < NUM_EVT; i++) begin
            if (pend_low[i]) begin
                sel_btn  = r_pend_btn[i];
                sel_kind = r_pend_kind[i];
            end
        end
    end

    // time since press and since last accepted press, modulo 2^32
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            held_d[i]  = r_in_time - r_press_start[i];
            since_d[i] = r_in_time - r_last_press[i];
        end
    end

    always_comb begin
        pin_ok      = 1'b0;
        pin_pressed = 1'b0;
        pin_slot    = '0;
        if (r_in_btn >= BTN_W'(1) && r_in_btn <= BTN_W'(USER_BUTTONS)) begin
            pin_ok      = 1'b1;
            pin_pressed = r_in_level;
            pin_slot    = SLOT_W'(r_in_btn - BTN_W'(1));
        end else if (r_in_btn == BOOT_ID) begin
            pin_ok      = 1'b1;
            pin_pressed = !r_in_level;
            pin_slot    = SLOT_W'(BOOT_SLOT);
        end
    end

    always_comb begin
        all_down = 1'b1;
        for (int i = 0; i < USER_BUTTONS; i++) begin
            if (!r_is_down[i]) begin
                all_down = 1'b0;
            end
        end
    end

    always_comb begin
        n_is_down     = r_is_down;
        n_press_start = r_press_start;
        n_last_press  = r_last_press;
        n_hold_rep    = r_hold_rep;
        n_click       = r_click;
        n_all_latch   = r_all_latch;
        n_all_start   = r_all_start;
        ev_mask       = '0;
        for (int i = 0; i < NUM_EVT; i++) begin
            ev_btn[i]  = '0;
            ev_kind[i] = KIND_SHORT;
        end

        if (!r_in_cmd) begin
            // pin change, its event sits in the first position
            if (pin_ok) begin
                if (pin_pressed) begin
                    if (!r_is_down[pin_slot] &&
                        since_d[pin_slot] >= TIME_W'(r_debounce)) begin
                        n_is_down[pin_slot]     = 1'b1;
                        n_press_start[pin_slot] = r_in_time;
                        n_last_press[pin_slot]  = r_in_time;
                        n_hold_rep[pin_slot]    = 1'b0;
                        if (since_d[pin_slot] < TIME_W'(r_double)) begin
                            if (r_click[pin_slot] != '1) begin
                                n_click[pin_slot] = r_click[pin_slot] + CLICK_W'(1);
                            end
                        end else begin
                            n_click[pin_slot] = CLICK_W'(1);
                        end
                    end
                end else if (r_is_down[pin_slot]) begin
                    n_is_down[pin_slot] = 1'b0;
                    if (!r_hold_rep[pin_slot]) begin
                        if (r_click[pin_slot] >= CLICK_W'(2)) begin
                            n_click[pin_slot] = '0;
                            ev_mask[0]        = 1'b1;
                            ev_btn[0]         = r_in_btn;
                            ev_kind[0]        = KIND_DOUBLE;
                        end else if (held_d[pin_slot] >= TIME_W'(r_long)) begin
                            ev_mask[0] = 1'b1;
                            ev_btn[0]  = r_in_btn;
                            ev_kind[0] = KIND_LONG;
                        end
                    end
                end
            end
        end else begin
            // tick: factory reset timer, re-armed after it fires
            if (all_down) begin
                if (!r_all_latch) begin
                    n_all_start = r_in_time;
                    n_all_latch = 1'b1;
                end else if (r_in_time - r_all_start >= TIME_W'(r_factory)) begin
                    n_all_latch = 1'b0;
                    n_all_start = '0;
                    ev_mask[0]  = 1'b1;
                    ev_btn[0]   = FACTORY_ID;
                    ev_kind[0]  = KIND_FACTORY;
                end
            end else begin
                n_all_latch = 1'b0;
                n_all_start = '0;
            end

            if (r_is_down[BOOT_SLOT] && !r_hold_rep[BOOT_SLOT] &&
                held_d[BOOT_SLOT] >= TIME_W'(r_very_long)) begin
                n_hold_rep[BOOT_SLOT] = 1'b1;
                ev_mask[1]            = 1'b1;
                ev_btn[1]             = BOOT_ID;
                ev_kind[1]            = KIND_PAIRING;
            end

            // hold events need the button down, short press needs it up
            for (int i = 0; i < USER_BUTTONS; i++) begin
                if (r_is_down[i] && !r_hold_rep[i]) begin
                    if (i == 0 && held_d[i] >= TIME_W'(r_very_long)) begin
                        n_hold_rep[i] = 1'b1;
                        ev_mask[i+2]  = 1'b1;
                        ev_btn[i+2]   = BTN_W'(i + 1);
                        ev_kind[i+2]  = KIND_PAIRING;
                    end else if (held_d[i] >= TIME_W'(r_long)) begin
                        n_hold_rep[i] = 1'b1;
                        ev_mask[i+2]  = 1'b1;
                        ev_btn[i+2]   = BTN_W'(i + 1);
                        ev_kind[i+2]  = KIND_LONG;
                    end
                end
                if (!r_is_down[i] && r_click[i] == CLICK_W'(1) &&
                    since_d[i] >= TIME_W'(r_double)) begin
                    n_click[i]   = '0;
                    ev_mask[i+2] = 1'b1;
                    ev_btn[i+2]  = BTN_W'(i + 1);
                    ev_kind[i+2] = KIND_SHORT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= DEBOUNCE_RST;
            r_double    <= DOUBLE_RST;
            r_long      <= LONG_RST;
            r_very_long <= VERY_LONG_RST;
            r_factory   <= FACTORY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE:  r_debounce  <= i_cfg_data[SHORT_CFG_W-1:0];
                REG_DOUBLE:    r_double    <= i_cfg_data[SHORT_CFG_W-1:0];
                REG_LONG:      r_long      <= i_cfg_data[SHORT_CFG_W-1:0];
                REG_VERY_LONG: r_very_long <= i_cfg_data[LONG_CFG_W-1:0];
                REG_FACTORY:   r_factory   <= i_cfg_data[LONG_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_cmd   <= s_axis_tuser;
            r_in_btn   <= s_axis_tdata[BTN_W-1:0];
            r_in_level <= s_axis_tdata[BTN_W];
            r_in_time  <= s_axis_tdata[BTN_W+TIME_W:BTN_W+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_is_down[i]     <= 1'b0;
                r_press_start[i] <= '0;
                r_last_press[i]  <= '0;
                r_hold_rep[i]    <= 1'b0;
                r_click[i]       <= '0;
            end
            r_all_latch <= 1'b0;
            r_all_start <= '0;
        end else if (proc_fire) begin
            r_is_down     <= n_is_down;
            r_press_start <= n_press_start;
            r_last_press  <= n_last_press;
            r_hold_rep    <= n_hold_rep;
            r_click       <= n_click;
            r_all_latch   <= n_all_latch;
            r_all_start   <= n_all_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_mask <= '0;
        end else if (proc_fire) begin
            r_pend_mask <= ev_mask;
        end else begin
            r_pend_mask <= pend_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_pend_btn  <= ev_btn;
            r_pend_kind <= ev_kind;
            r_pend_time <= r_in_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= load_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_btn  <= sel_btn;
            r_out_kind <= sel_kind;
            r_out_time <= r_pend_time;
            r_out_last <= (pend_rest == '0);
        end
    end

endmodule

`default_nettype wire

[hdl/bgc_checker.sv]
// port-level checks of the button gesture classifier and their bind
`default_nettype none

module bgc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [bgc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [2:0]                    m_axis_tuser,
    input wire logic                          m_axis_tlast
);

    import bgc_pkg::*;

    logic [BTN_W-1:0] out_btn;

    assign out_btn = m_axis_tdata[BTN_W-1:0];

    // a stalled result transaction holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // factory reset and only factory reset carries the all-buttons id
    a_factory_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tuser == KIND_FACTORY) == (out_btn == FACTORY_ID)))
        else $error("factory reset button id mismatch");

    // pairing comes from button one or the boot button only
    a_pairing_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_PAIRING |->
            out_btn == BTN_W'(1) || out_btn == BOOT_ID)
        else $error("pairing from wrong button");

    // the boot button never reports a short press
    a_boot_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_SHORT |-> out_btn != BOOT_ID)
        else $error("short press from boot button");

endmodule

bind button_gesture_classifier bgc_checker u_bgc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
